// File: sv/ucst_pkg.sv
`timescale 1ns / 1ps

package ucst_pkg;

   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_CONTAINS = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_CLEAR    = 2'd3
   } op_kind_type;

   typedef struct packed {
      logic active;
      logic found;
   } token_ctl_type;

endpackage

// File: sv/ucst_cell.sv
`timescale 1ns / 1ps

module ucst_cell #(
   parameter int IDX   = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_idx,
   input  logic [ucst_pkg::VALUE_W-1:0]  wr_data,
   input  logic [ucst_pkg::VALUE_W-1:0]  key,
   input  logic [CNT_W-1:0]              count,
   input  ucst_pkg::token_ctl_type       tok_ctl_i,
   input  logic [IDX_W-1:0]              tok_slot_i,
   input  logic [ucst_pkg::VALUE_W-1:0]  tok_data_i,
   output ucst_pkg::token_ctl_type       tok_ctl_o,
   output logic [IDX_W-1:0]              tok_slot_o,
   output logic [ucst_pkg::VALUE_W-1:0]  tok_data_o
);
   import ucst_pkg::*;

   logic [VALUE_W-1:0] entry_ff;
   token_ctl_type      tok_ctl_ff, tok_ctl_in;
   logic [IDX_W-1:0]   tok_slot_ff, tok_slot_in;
   logic [VALUE_W-1:0] tok_data_ff, tok_data_in;
   logic               in_bound;
   logic               is_last;
   logic               match;

   assign in_bound = CNT_W'(IDX) < count;
   assign is_last  = CNT_W'(IDX + 1) == count;
   assign match    = tok_ctl_i.active && !tok_ctl_i.found && in_bound && (entry_ff == key);

   always_comb begin
      tok_ctl_in.active = tok_ctl_i.active;
      tok_ctl_in.found  = tok_ctl_i.found | match;
      tok_slot_in       = match ? IDX_W'(IDX) : tok_slot_i;
      tok_data_in       = (tok_ctl_i.active && is_last) ? entry_ff : tok_data_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ctl_ff <= '0;
      end else begin
         tok_ctl_ff <= tok_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_slot_ff <= tok_slot_in;
      tok_data_ff <= tok_data_in;
      if (wr_en && (wr_idx == IDX_W'(IDX))) begin
         entry_ff <= wr_data;
      end
   end

   assign tok_ctl_o  = tok_ctl_ff;
   assign tok_slot_o = tok_slot_ff;
   assign tok_data_o = tok_data_ff;

endmodule

// File: sv/unsorted_int_set_table.sv
// add and clear: result registered at the request transfer, valid in the next cycle
// contains and remove: a search token launched from a register steps through the
// row of cells one cell per cycle; the result is posted once the output is free
// one request in flight at a time; next transfer taken once the result is posted
// synchronous active-high reset clears the entry count and the token chain;
// stored entries are not cleared and no clearing pass is run
`timescale 1ns / 1ps

module unsorted_int_set_table #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_kind,
   input  logic signed [ucst_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_success,
   output logic                              rsp_full_reject,
   output logic [ucst_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);
   import ucst_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [VALUE_W-1:0]   key_ff, key_in;
   logic                 rm_ff, rm_in;
   token_ctl_type        launch_ff, launch_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [VALUE_W-1:0]   last_ff, last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_success_ff, rsp_success_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                 out_free;
   logic                 req_fire;
   logic                 post;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   logic [VALUE_W-1:0]   wr_data;
   op_kind_type          kind;

   token_ctl_type        tok_ctl  [0:CAPACITY];
   logic [IDX_W-1:0]     tok_slot [0:CAPACITY];
   logic [VALUE_W-1:0]   tok_data [0:CAPACITY];

   assign kind      = op_kind_type'(req_kind);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;

   assign tok_ctl[0]  = launch_ff;
   assign tok_slot[0] = '0;
   assign tok_data[0] = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ucst_cell #(
         .IDX   (g),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_en),
         .wr_idx     (wr_idx),
         .wr_data    (wr_data),
         .key        (key_ff),
         .count      (count_ff),
         .tok_ctl_i  (tok_ctl[g]),
         .tok_slot_i (tok_slot[g]),
         .tok_data_i (tok_data[g]),
         .tok_ctl_o  (tok_ctl[g+1]),
         .tok_slot_o (tok_slot[g+1]),
         .tok_data_o (tok_data[g+1])
      );
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      key_in         = key_ff;
      rm_in          = rm_ff;
      launch_in      = '0;
      found_in       = found_ff;
      slot_in        = slot_ff;
      last_in        = last_ff;
      post           = 1'b0;
      rsp_success_in = rsp_success_ff;
      rsp_full_in    = rsp_full_ff;
      wr_en          = 1'b0;
      wr_idx         = count_ff[IDX_W-1:0];
      wr_data        = $unsigned(req_value);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (kind)
                  OP_ADD: begin
                     post = 1'b1;
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_success_in = 1'b0;
                        rsp_full_in    = 1'b1;
                     end else begin
                        wr_en          = 1'b1;
                        count_in       = count_ff + 1'b1;
                        rsp_success_in = 1'b1;
                        rsp_full_in    = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     post           = 1'b1;
                     count_in       = '0;
                     rsp_success_in = 1'b1;
                     rsp_full_in    = 1'b0;
                  end
                  default: begin
                     key_in           = $unsigned(req_value);
                     rm_in            = (kind == OP_REMOVE);
                     launch_in.active = 1'b1;
                     launch_in.found  = 1'b0;
                     state_in         = ST_WALK;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (tok_ctl[CAPACITY].active) begin
               found_in = tok_ctl[CAPACITY].found;
               slot_in  = tok_slot[CAPACITY];
               last_in  = tok_data[CAPACITY];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               post           = 1'b1;
               rsp_success_in = found_ff;
               rsp_full_in    = 1'b0;
               state_in       = ST_IDLE;
               if (rm_ff && found_ff) begin
                  wr_en    = 1'b1;
                  wr_idx   = slot_ff;
                  wr_data  = last_ff;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = post ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_count_in = post ? COUNT_OUT_W'(count_in) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      rm_ff          <= rm_in;
      found_ff       <= found_in;
      slot_ff        <= slot_in;
      last_ff        <= last_in;
      rsp_success_ff <= rsp_success_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_full_reject = rsp_full_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_reject_no_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_reject |-> !rsp_success)
      else $error("full reject reported with success");

   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> !wr_en)
      else $error("entry write while token walks");

   a_token_exit_in_walk: assert property (@(posedge clock) disable iff (reset)
      tok_ctl[CAPACITY].active |-> state_ff == ST_WALK)
      else $error("token left the chain outside a search");

   a_search_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_fire && (kind == OP_CONTAINS || kind == OP_REMOVE) |=> state_ff == ST_WALK)
      else $error("search transfer did not start a walk");
`endif

endmodule

// File: sim/unsorted_int_set_table_tb.sv
`timescale 1ns / 1ps

module unsorted_int_set_table_tb;
   import ucst_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 160;
   localparam int DRAIN_WAIT  = CAPACITY + 20;

   typedef struct packed {
      logic                   success;
      logic                   full_reject;
      logic [COUNT_OUT_W-1:0] entry_count;
   } set_rsp_type;

   typedef struct packed {
      op_kind_type      op;
      logic [VALUE_W-1:0] value;
      logic             known;
      set_rsp_type      rsp;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_kind = OP_CLEAR;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_success;
   logic                      rsp_full_reject;
   logic [COUNT_OUT_W-1:0]    rsp_entry_count;

   logic [VALUE_W-1:0] slot_values [CAPACITY];
   int                 slot_fill;
   set_rsp_type        pending_rsp [$];
   int                 error_count;
   int                 rsp_count;
   int                 cycle_count;
   int                 send_idle_pct;
   int                 rsp_stall_pct;

   stim_row_type directed_rows [22] = '{
      '{OP_CONTAINS, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_REMOVE,   32'h8000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_CLEAR,    32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd0}},
      '{OP_ADD,      32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd1}},
      '{OP_ADD,      32'h7fff_ffff, 1'b1, '{1'b1, 1'b0, 7'd2}},
      '{OP_ADD,      32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd3}},
      '{OP_ADD,      32'hffff_ffff, 1'b1, '{1'b1, 1'b0, 7'd4}},
      '{OP_ADD,      32'h7fff_ffff, 1'b1, '{1'b1, 1'b0, 7'd5}},
      '{OP_CONTAINS, 32'h8000_0000, 1'b0, '0},
      '{OP_CONTAINS, 32'h7fff_fffe, 1'b0, '0},
      '{OP_REMOVE,   32'h7fff_ffff, 1'b0, '0},
      '{OP_CONTAINS, 32'h7fff_ffff, 1'b0, '0},
      '{OP_REMOVE,   32'h8000_0000, 1'b0, '0},
      '{OP_REMOVE,   32'h1234_5678, 1'b0, '0},
      '{OP_CONTAINS, 32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE,   32'hffff_ffff, 1'b0, '0},
      '{OP_REMOVE,   32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE,   32'h7fff_ffff, 1'b0, '0},
      '{OP_REMOVE,   32'h7fff_ffff, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_ADD,      32'h5a5a_5a5a, 1'b1, '{1'b1, 1'b0, 7'd1}},
      '{OP_CLEAR,    32'hffff_ffff, 1'b1, '{1'b1, 1'b0, 7'd0}},
      '{OP_CONTAINS, 32'h5a5a_5a5a, 1'b1, '{1'b0, 1'b0, 7'd0}}
   };

   int send_idle_table [4] = '{0, 72, 0, 14};
   int rsp_stall_table [4] = '{0, 0, 72, 14};

   unsorted_int_set_table #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_success(rsp_success),
      .rsp_full_reject(rsp_full_reject),
      .rsp_entry_count(rsp_entry_count)
   );

   always #5 clock = ~clock;

   function automatic set_rsp_type apply_set_op(op_kind_type op, logic [VALUE_W-1:0] v);
      set_rsp_type r;
      int          hit;
      r   = '0;
      hit = -1;
      for (int i = 0; i < slot_fill; i++) begin
         if (hit < 0 && slot_values[i] == v) begin
            hit = i;
         end
      end
      case (op)
         OP_ADD: begin
            if (slot_fill >= CAPACITY) begin
               r.full_reject = 1'b1;
            end else begin
               slot_values[slot_fill] = v;
               slot_fill++;
               r.success = 1'b1;
            end
         end
         OP_CONTAINS: begin
            r.success = (hit >= 0);
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               slot_values[hit] = slot_values[slot_fill - 1];
               slot_fill--;
               r.success = 1'b1;
            end
         end
         default: begin
            slot_fill = 0;
            r.success = 1'b1;
         end
      endcase
      r.entry_count = slot_fill[COUNT_OUT_W-1:0];
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 55 && slot_fill > 0) begin
         return slot_values[$urandom_range(slot_fill - 1)];
      end
      if (r < 70) begin
         case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            default: return 32'h7fff_ffff;
         endcase
      end
      if (r < 80) begin
         return VALUE_W'($urandom_range(15));
      end
      return $urandom();
   endfunction

   function automatic op_kind_type pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 40) begin
         return OP_ADD;
      end
      if (r < 70) begin
         return OP_CONTAINS;
      end
      if (r < 97) begin
         return OP_REMOVE;
      end
      return OP_CLEAR;
   endfunction

   task automatic send_item(op_kind_type op, logic [VALUE_W-1:0] v, logic known,
                            set_rsp_type known_rsp);
      set_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= op;
      req_value <= v;
      do begin
         @(posedge clock);
      end while (!(req_valid && !req_stall));
      predicted = apply_set_op(op, v);
      pending_rsp.push_back(known ? known_rsp : predicted);
   endtask

   task automatic send_mixed(int n);
      for (int i = 0; i < n; i++) begin
         send_item(pick_op(), pick_value(), 1'b0, '0);
      end
   endtask

   task automatic fill_to_full(output int n);
      n = 0;
      while (slot_fill < CAPACITY) begin
         send_item(OP_ADD, pick_value(), 1'b0, '0);
         n++;
      end
      repeat ($urandom_range(1, 3)) begin
         send_item(OP_ADD, $urandom(), 1'b0, '0);
         n++;
      end
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on transfer %0d: %s got %0d expected %0d",
               rsp_count, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      set_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transfer, success", rsp_success, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_success !== want.success) begin
               report_mismatch("success", rsp_success, want.success);
            end
            if (rsp_full_reject !== want.full_reject) begin
               report_mismatch("full_reject", rsp_full_reject, want.full_reject);
            end
            if (rsp_entry_count !== want.entry_count) begin
               report_mismatch("entry_count", rsp_entry_count, want.entry_count);
            end
         end
         rsp_count++;
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int filled;
      slot_fill     = 0;
      error_count   = 0;
      rsp_count     = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].known,
                   directed_rows[i].rsp);
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_idle_table[p];
         rsp_stall_pct = rsp_stall_table[p];
         send_mixed(PHASE_ITEMS / 2);
         fill_to_full(filled);
         if (filled < PHASE_ITEMS / 2) begin
            send_mixed(PHASE_ITEMS / 2 - filled);
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
sv/ucst_pkg.sv
sv/ucst_cell.sv
sv/unsorted_int_set_table.sv
sim/unsorted_int_set_table_tb.sv
